[src/pqual_pkg.sv]
// Shared types and constants for the panel input qualifier.
package pqual_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_TIME      = 2'd0,
        REG_BLINK_PERIOD   = 2'd1,
        REG_BLINK_TOGGLES  = 2'd2,
        REG_SAFETY_DEBOUNCE = 2'd3
    } t_cfg_reg;

    localparam logic [MS_W-1:0]  HOLD_TIME_RST       = 16'd200;
    localparam logic [MS_W-1:0]  BLINK_PERIOD_RST    = 16'd200;
    localparam logic [CNT_W-1:0] BLINK_TOGGLES_RST   = 5'd14;
    localparam logic [MS_W-1:0]  SAFETY_DEBOUNCE_RST = 16'd100;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              thermostat_low;
        logic              remote_thermostat;
        logic              interlock_low;
        logic              door_high;
        logic              button_low;
        logic              safety_high;
        logic              blink_request;
    } t_in;

    typedef struct packed {
        logic thermostat_on;
        logic interlock_on;
        logic door_open;
        logic button_raw;
        logic reload_request;
        logic blink_busy;
        logic led_on;
        logic safety_on;
    } t_out;

endpackage

[src/panel_input_qualifier.sv]
// Panel input qualifier: heat demand, button hold, LED blink and safety debounce.
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_data): one request per
//   sample tick, carrying the millisecond time stamp and the raw pin levels.
//   Output channel (o_out_valid / i_out_ready / o_out_data): exactly one
//   result per request, in order, holding the qualified levels after that
//   tick's update.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   always ready; write only while no request is in flight. Index 0 hold
//   time, 1 blink period, 2 blink toggle count (low 5 bits), 3 safety
//   debounce.
// Timing
//   Two register stages: input register, then result register. A result
//   is computed from the input register and held in the result register
//   until taken; one request per cycle is sustained while i_out_ready
//   stays high. That rate rests on the tick state update (three 32-bit
//   elapsed-time compares) that sits between the two registers.
// Reset
//   Synchronous, active low: both stages empty, all timers and flags clear,
//   LED off, config registers at their defaults (200, 200, 14, 100).
// Stall
//   When the receiver holds i_out_ready low the result register holds, the
//   input register fills, and then o_in_ready drops; nothing is lost.
module panel_input_qualifier (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  pqual_pkg::t_in                        i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output pqual_pkg::t_out                       o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pqual_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pqual_pkg::MS_W-1:0]            i_cfg_data
);

    // config registers
    logic [pqual_pkg::MS_W-1:0]  r_hold_time;
    logic [pqual_pkg::MS_W-1:0]  r_blink_period;
    logic [pqual_pkg::CNT_W-1:0] r_blink_toggles;
    logic [pqual_pkg::MS_W-1:0]  r_safety_debounce;

    // pipeline
    logic            r_in_vld;
    pqual_pkg::t_in  r_in;
    logic            r_out_vld;
    pqual_pkg::t_out r_out;
    logic            advance;

    // tick state
    logic [pqual_pkg::TIME_W-1:0] r_press_start,  n_press_start;
    logic                         r_press_timing, n_press_timing;
    logic                         r_press_latched, n_press_latched;
    logic                         r_reload,       n_reload;
    logic                         r_blink_active, n_blink_active;
    logic [pqual_pkg::CNT_W-1:0]  r_blink_count,  n_blink_count;
    logic [pqual_pkg::TIME_W-1:0] r_blink_last,   n_blink_last;
    logic                         r_led,          n_led;
    logic [pqual_pkg::TIME_W-1:0] r_safety_start, n_safety_start;
    logic                         r_safety_timing, n_safety_timing;
    logic                         r_safety_flag,  n_safety_flag;
    pqual_pkg::t_out              n_out;

    // elapsed times, modulo 2^32
    logic [pqual_pkg::TIME_W-1:0] press_elapsed;
    logic [pqual_pkg::TIME_W-1:0] blink_elapsed;
    logic [pqual_pkg::TIME_W-1:0] safety_elapsed;
    logic                         hold_done;
    logic                         blink_due;
    logic                         safety_done;
    logic                         blink_go;

    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign press_elapsed  = r_in.now_ms - r_press_start;
    assign blink_elapsed  = r_in.now_ms - r_blink_last;
    assign safety_elapsed = r_in.now_ms - r_safety_start;

    assign hold_done   = press_elapsed  >
                         {{(pqual_pkg::TIME_W-pqual_pkg::MS_W){1'b0}}, r_hold_time};
    assign blink_due   = blink_elapsed  >
                         {{(pqual_pkg::TIME_W-pqual_pkg::MS_W){1'b0}}, r_blink_period};
    assign safety_done = safety_elapsed >
                         {{(pqual_pkg::TIME_W-pqual_pkg::MS_W){1'b0}}, r_safety_debounce};

    always_comb begin
        n_press_start   = r_press_start;
        n_press_timing  = r_press_timing;
        n_press_latched = r_press_latched;
        n_reload        = r_reload;
        n_blink_active  = r_blink_active;
        n_blink_count   = r_blink_count;
        n_blink_last    = r_blink_last;
        n_led           = r_led;
        n_safety_start  = r_safety_start;
        n_safety_timing = r_safety_timing;
        n_safety_flag   = r_safety_flag;

        // button hold; any release drops timing and request
        if (r_in.button_low) begin
            if (!r_press_latched) begin
                if (!r_press_timing) begin
                    n_press_start  = r_in.now_ms;
                    n_press_timing = 1'b1;
                end else if (hold_done) begin
                    n_reload        = 1'b1;
                    n_press_latched = 1'b1;
                end
            end
        end else begin
            n_press_timing  = 1'b0;
            n_press_latched = 1'b0;
            n_reload        = 1'b0;
        end

        // blink: a request restarts the count, last toggle time is kept
        blink_go = r_blink_active || r_in.blink_request;
        if (r_in.blink_request) begin
            n_blink_active = 1'b1;
            n_blink_count  = '0;
        end
        if (blink_go && blink_due) begin
            if (n_blink_count >= r_blink_toggles) begin
                n_blink_active = 1'b0;
                n_blink_count  = '0;
            end else begin
                n_led         = !r_led;
                n_blink_count = n_blink_count + 1'b1;
                n_blink_last  = r_in.now_ms;
            end
        end

        // safety debounce, strictly longer than the set time
        if (r_in.safety_high) begin
            if (!r_safety_timing) begin
                n_safety_start  = r_in.now_ms;
                n_safety_timing = 1'b1;
            end else if (safety_done) begin
                n_safety_flag = 1'b1;
            end
        end else begin
            n_safety_timing = 1'b0;
            n_safety_flag   = 1'b0;
        end

        n_out.thermostat_on  = r_in.thermostat_low | r_in.remote_thermostat;
        n_out.interlock_on   = r_in.interlock_low;
        n_out.door_open      = r_in.door_high;
        n_out.button_raw     = r_in.button_low;
        n_out.reload_request = n_reload;
        n_out.blink_busy     = n_blink_active;
        n_out.led_on         = n_led;
        n_out.safety_on      = n_safety_flag;
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time       <= pqual_pkg::HOLD_TIME_RST;
            r_blink_period    <= pqual_pkg::BLINK_PERIOD_RST;
            r_blink_toggles   <= pqual_pkg::BLINK_TOGGLES_RST;
            r_safety_debounce <= pqual_pkg::SAFETY_DEBOUNCE_RST;
        end else if (i_cfg_valid) begin
            unique case (pqual_pkg::t_cfg_reg'(i_cfg_index))
                pqual_pkg::REG_HOLD_TIME:       r_hold_time <= i_cfg_data;
                pqual_pkg::REG_BLINK_PERIOD:    r_blink_period <= i_cfg_data;
                pqual_pkg::REG_BLINK_TOGGLES:   r_blink_toggles <= i_cfg_data[pqual_pkg::CNT_W-1:0];
                pqual_pkg::REG_SAFETY_DEBOUNCE: r_safety_debounce <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // tick state, updated once per request as it moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_start   <= '0;
            r_press_timing  <= 1'b0;
            r_press_latched <= 1'b0;
            r_reload        <= 1'b0;
            r_blink_active  <= 1'b0;
            r_blink_count   <= '0;
            r_blink_last    <= '0;
            r_led           <= 1'b0;
            r_safety_start  <= '0;
            r_safety_timing <= 1'b0;
            r_safety_flag   <= 1'b0;
        end else if (advance) begin
            r_press_start   <= n_press_start;
            r_press_timing  <= n_press_timing;
            r_press_latched <= n_press_latched;
            r_reload        <= n_reload;
            r_blink_active  <= n_blink_active;
            r_blink_count   <= n_blink_count;
            r_blink_last    <= n_blink_last;
            r_led           <= n_led;
            r_safety_start  <= n_safety_start;
            r_safety_timing <= n_safety_timing;
            r_safety_flag   <= n_safety_flag;
        end
    end

endmodule

[sim/tb_panel_input_qualifier.sv]
// Self-checking testbench for panel_input_qualifier: directed and random ticks vs. a predictor.
module tb_panel_input_qualifier;
    timeunit 1ns;
    timeprecision 1ps;

    // Pin masks for the low seven bits of t_in, in struct order below now_ms
    localparam logic [6:0] P_THERMO    = 7'b1000000;
    localparam logic [6:0] P_REMOTE    = 7'b0100000;
    localparam logic [6:0] P_INTERLOCK = 7'b0010000;
    localparam logic [6:0] P_DOOR      = 7'b0001000;
    localparam logic [6:0] P_BUTTON    = 7'b0000100;
    localparam logic [6:0] P_SAFETY    = 7'b0000010;
    localparam logic [6:0] P_BLINK     = 7'b0000001;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    pqual_pkg::t_in                  i_in_data;
    logic                            o_out_valid;
    logic                            i_out_ready;
    pqual_pkg::t_out                 o_out_data;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [pqual_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [pqual_pkg::MS_W-1:0]      i_cfg_data;

    panel_input_qualifier uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor: configuration and timer state mirrored on the bench side
    // ------------------------------------------------------------------
    logic [pqual_pkg::MS_W-1:0]   hold_ms;
    logic [pqual_pkg::MS_W-1:0]   blink_period;
    logic [pqual_pkg::CNT_W-1:0]  blink_toggles;
    logic [pqual_pkg::MS_W-1:0]   debounce_ms;

    logic [pqual_pkg::TIME_W-1:0] press_t0;
    logic                         press_timing;
    logic                         press_latched;
    logic                         reload_set;
    logic                         blink_running;
    logic [pqual_pkg::CNT_W-1:0]  blink_done;
    logic [pqual_pkg::TIME_W-1:0] blink_t_last;
    logic                         led_level;
    logic [pqual_pkg::TIME_W-1:0] safety_t0;
    logic                         safety_timing;
    logic                         safety_set;

    pqual_pkg::t_out              pending_results[$];  // qualified levels still owed
    int                           fault_count;
    int                           idle_pct;       // sender: chance of an empty cycle
    int                           stall_pct;      // receiver: chance of ready low
    int                           tick_step_max;  // largest time advance between ticks
    logic [pqual_pkg::TIME_W-1:0] clock_ms;       // running time stamp of random traffic

    function automatic void clear_panel_state();
        hold_ms       = pqual_pkg::HOLD_TIME_RST;
        blink_period  = pqual_pkg::BLINK_PERIOD_RST;
        blink_toggles = pqual_pkg::BLINK_TOGGLES_RST;
        debounce_ms   = pqual_pkg::SAFETY_DEBOUNCE_RST;
        press_t0      = '0;
        press_timing  = 1'b0;
        press_latched = 1'b0;
        reload_set    = 1'b0;
        blink_running = 1'b0;
        blink_done    = '0;
        blink_t_last  = '0;
        led_level     = 1'b0;
        safety_t0     = '0;
        safety_timing = 1'b0;
        safety_set    = 1'b0;
    endfunction

    // One tick of the panel: update timers and flags, return the levels after the update.
    // All elapsed times wrap modulo 2^32.
    function automatic pqual_pkg::t_out qualify_tick(input pqual_pkg::t_in x);
        pqual_pkg::t_out              y;
        logic [pqual_pkg::TIME_W-1:0] held;
        logic [pqual_pkg::TIME_W-1:0] since_toggle;
        logic [pqual_pkg::TIME_W-1:0] safety_age;
        held         = x.now_ms - press_t0;
        since_toggle = x.now_ms - blink_t_last;
        safety_age   = x.now_ms - safety_t0;

        // Button: any release restarts the press timer
        if (x.button_low) begin
            if (!press_latched) begin
                if (!press_timing) begin
                    press_t0     = x.now_ms;
                    press_timing = 1'b1;
                end else if (held > {16'd0, hold_ms}) begin
                    reload_set    = 1'b1;
                    press_latched = 1'b1;
                end
            end
        end else begin
            press_timing  = 1'b0;
            press_latched = 1'b0;
            reload_set    = 1'b0;
        end

        // Blink: a request restarts the count but keeps the last toggle time
        if (x.blink_request) begin
            blink_running = 1'b1;
            blink_done    = '0;
        end
        if (blink_running && since_toggle > {16'd0, blink_period}) begin
            if (blink_done >= blink_toggles) begin
                blink_running = 1'b0;
                blink_done    = '0;
            end else begin
                led_level    = !led_level;
                blink_done   = blink_done + 1'b1;
                blink_t_last = x.now_ms;
            end
        end

        // Safety: asserts only after strictly more than the debounce time
        if (x.safety_high) begin
            if (!safety_timing) begin
                safety_t0     = x.now_ms;
                safety_timing = 1'b1;
            end else if (safety_age > {16'd0, debounce_ms}) begin
                safety_set = 1'b1;
            end
        end else begin
            safety_timing = 1'b0;
            safety_set    = 1'b0;
        end

        y.thermostat_on  = x.thermostat_low | x.remote_thermostat;
        y.interlock_on   = x.interlock_low;
        y.door_open      = x.door_high;
        y.button_raw     = x.button_low;
        y.reload_request = reload_set;
        y.blink_busy     = blink_running;
        y.led_on         = led_level;
        y.safety_on      = safety_set;
        return y;
    endfunction

    function automatic pqual_pkg::t_in pins_at(input logic [pqual_pkg::TIME_W-1:0] t,
                                               input logic [6:0] pins);
        return pqual_pkg::t_in'({t, pins});
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Time limit set well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: ready is redrawn at each falling edge with the current stall rate
    // ------------------------------------------------------------------
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_bit(input string name, input logic want, input logic got);
        if (got !== want) begin
            fault_count++;
            $display("%0t ns: %s mismatch, expected %b actual %b", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        pqual_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                fault_count++;
                $display("%0t ns: unexpected result, expected none actual %b",
                         $time, o_out_data);
            end else begin
                want = pending_results.pop_front();
                check_bit("thermostat_on",  want.thermostat_on,  o_out_data.thermostat_on);
                check_bit("interlock_on",   want.interlock_on,   o_out_data.interlock_on);
                check_bit("door_open",      want.door_open,      o_out_data.door_open);
                check_bit("button_raw",     want.button_raw,     o_out_data.button_raw);
                check_bit("reload_request", want.reload_request, o_out_data.reload_request);
                check_bit("blink_busy",     want.blink_busy,     o_out_data.blink_busy);
                check_bit("led_on",         want.led_on,         o_out_data.led_on);
                check_bit("safety_on",      want.safety_on,      o_out_data.safety_on);
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Send one tick request; valid stays high after acceptance so that a
    // following request can go out back to back.
    task automatic send_tick(input pqual_pkg::t_in x);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= x;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(qualify_tick(x));
    endtask

    // Drop valid and hold off until every owed result has come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Register write; only issued with the block idle
    task automatic write_reg(input pqual_pkg::t_cfg_reg idx,
                             input logic [pqual_pkg::MS_W-1:0] val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            pqual_pkg::REG_HOLD_TIME:       hold_ms       = val;
            pqual_pkg::REG_BLINK_PERIOD:    blink_period  = val;
            pqual_pkg::REG_BLINK_TOGGLES:   blink_toggles = val[pqual_pkg::CNT_W-1:0];
            pqual_pkg::REG_SAFETY_DEBOUNCE: debounce_ms   = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic. Most of it is press episodes: button and/or safety
    // held over a run of ticks with small time steps (with a rare glitch
    // release), then released. The rest is noise with fully random stamps.
    task automatic run_traffic(input int items);
        int             sent;
        int             len;
        logic           btn_hold;
        logic           saf_hold;
        pqual_pkg::t_in x;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(99) < 80) begin
                len      = $urandom_range(3, 24);
                btn_hold = ($urandom_range(3) != 0);
                saf_hold = ($urandom_range(1) != 0);
                for (int k = 0; k < len; k++) begin
                    clock_ms        += $urandom_range(0, tick_step_max);
                    x               = pqual_pkg::t_in'({clock_ms, 7'($urandom)});
                    x.button_low    = btn_hold && (k < len - 1) && ($urandom_range(19) != 0);
                    x.safety_high   = saf_hold && (k < len - 1) && ($urandom_range(19) != 0);
                    x.blink_request = (k == 0) ? ($urandom_range(2) == 0)
                                               : ($urandom_range(49) == 0);
                    send_tick(x);
                    sent++;
                end
            end else begin
                x        = pqual_pkg::t_in'({32'($urandom), 7'($urandom)});
                clock_ms = x.now_ms;
                send_tick(x);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Pass-through pins and the heat demand OR
    task automatic test_pin_levels();
        send_tick(pins_at(32'd0, 7'b0));
        send_tick(pins_at(32'd10, P_THERMO));
        send_tick(pins_at(32'd20, P_REMOTE));
        send_tick(pins_at(32'd30, P_THERMO | P_REMOTE | P_INTERLOCK | P_DOOR));
    endtask

    // Reload request: strictly longer than the hold time, cleared on release,
    // and a release in between restarts the timer
    task automatic test_button_hold();
        send_tick(pins_at(32'd1000, P_BUTTON));
        send_tick(pins_at(32'd1200, P_BUTTON));     // exactly the hold time: not yet
        send_tick(pins_at(32'd1201, P_BUTTON));     // past it: reload
        send_tick(pins_at(32'd1500, P_BUTTON));     // latched while held
        send_tick(pins_at(32'd1501, 7'b0));         // release clears
        send_tick(pins_at(32'd1600, P_BUTTON));
        send_tick(pins_at(32'd1601, 7'b0));         // short release
        send_tick(pins_at(32'd1700, P_BUTTON));     // timer starts over here
        send_tick(pins_at(32'd1850, P_BUTTON));     // 250 from first press, 150 from restart
    endtask

    task automatic test_safety_debounce();
        send_tick(pins_at(32'd2000, P_SAFETY));
        send_tick(pins_at(32'd2100, P_SAFETY));     // exactly the debounce: not yet
        send_tick(pins_at(32'd2101, P_SAFETY));
        send_tick(pins_at(32'd2102, 7'b0));
    endtask

    // Blink start, period edge, and a restart while a sequence is running
    task automatic test_blink_sequence();
        send_tick(pins_at(32'd3000, P_BLINK));
        send_tick(pins_at(32'd3200, 7'b0));         // exactly one period: no toggle
        send_tick(pins_at(32'd3201, 7'b0));
        send_tick(pins_at(32'd3202, P_BLINK));
    endtask

    // Press and debounce timers across the 32-bit wrap of the time stamp
    task automatic test_time_wrap();
        send_tick(pins_at(32'hFFFF_FFFF, P_BUTTON | P_SAFETY));
        send_tick(pins_at(32'h0000_00C9, P_BUTTON | P_SAFETY | P_THERMO | P_DOOR));
    endtask

    // Every register at both ends, including a toggle count of zero
    task automatic test_config_extremes();
        write_reg(pqual_pkg::REG_HOLD_TIME, 16'd0);
        write_reg(pqual_pkg::REG_SAFETY_DEBOUNCE, 16'd0);
        write_reg(pqual_pkg::REG_BLINK_PERIOD, 16'd0);
        write_reg(pqual_pkg::REG_BLINK_TOGGLES, 16'd1);
        send_tick(pins_at(32'd5000, P_BUTTON | P_SAFETY | P_BLINK));
        send_tick(pins_at(32'd5000, P_BUTTON | P_SAFETY));     // zero elapsed: not past
        send_tick(pins_at(32'd5001, P_BUTTON | P_SAFETY));
        send_tick(pins_at(32'd5002, 7'b0));

        // upper bits dropped: toggle count of zero ends the sequence at once
        write_reg(pqual_pkg::REG_BLINK_TOGGLES, 16'hFFE0);
        send_tick(pins_at(32'd5010, P_BLINK));
        send_tick(pins_at(32'd5011, 7'b0));

        write_reg(pqual_pkg::REG_HOLD_TIME, 16'hFFFF);
        write_reg(pqual_pkg::REG_SAFETY_DEBOUNCE, 16'hFFFF);
        write_reg(pqual_pkg::REG_BLINK_PERIOD, 16'hFFFF);
        write_reg(pqual_pkg::REG_BLINK_TOGGLES, 16'd31);
        send_tick(pins_at(32'd6000, P_BUTTON | P_SAFETY | P_BLINK));
        send_tick(pins_at(32'd71535, P_BUTTON | P_SAFETY));
        send_tick(pins_at(32'd71536, P_BUTTON | P_SAFETY));

        clock_ms      = 32'd80000;
        tick_step_max = 20000;
        run_traffic(40);
    endtask

    // One random phase: fresh settings, given idle and stall rates.
    // With hold_off set, the sender stops halfway until all results are in.
    task automatic run_phase(input int idle, input int stall, input int items,
                             input bit hold_off);
        write_reg(pqual_pkg::REG_HOLD_TIME, 16'($urandom_range(0, 300)));
        write_reg(pqual_pkg::REG_BLINK_PERIOD, 16'($urandom_range(0, 120)));
        write_reg(pqual_pkg::REG_BLINK_TOGGLES, 16'($urandom));
        write_reg(pqual_pkg::REG_SAFETY_DEBOUNCE, 16'($urandom_range(0, 300)));
        idle_pct      = idle;
        stall_pct     = stall;
        tick_step_max = 40;
        if (hold_off) begin
            run_traffic(items / 2);
            wait_idle();
            run_traffic(items - items / 2);
        end else begin
            run_traffic(items);
        end
    endtask

    task automatic test_random_phases();
        run_phase(0, 0, 150, 1'b0);
        run_phase(86, 0, 150, 1'b1);
        run_phase(0, 86, 150, 1'b0);
        run_phase(33, 33, 150, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = pqual_pkg::REG_HOLD_TIME;
        i_cfg_data    = '0;
        fault_count   = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        tick_step_max = 40;
        clock_ms      = '0;
        clear_panel_state();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed checks at reset defaults first, then config extremes and random phases
        test_pin_levels();
        test_button_hold();
        test_safety_debounce();
        test_blink_sequence();
        test_time_wrap();
        test_config_extremes();
        test_random_phases();

        // Let everything drain, then keep watching the output for strays
        wait_idle();
        repeat (10) @(posedge i_clk);

        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
src/pqual_pkg.sv
src/panel_input_qualifier.sv
sim/tb_panel_input_qualifier.sv
